// File: hw/rtl/rrfp_pkg.sv
// ----------------------------------------------------------------------------
// Radar report frame parser package
// Parse phase codes, frame event codes, register indexes and the fixed
// header and tail byte patterns of a report frame.
// ----------------------------------------------------------------------------
`default_nettype none

package rrfp_pkg;

   localparam int unsigned PhaseW = 3;
   localparam int unsigned EventW = 2;
   localparam int unsigned ByteW = 8;
   localparam int unsigned CsrDataW = 16;
   localparam int unsigned CsrIndexW = 1;
   localparam int unsigned AgeW = 16;
   localparam int unsigned RawW = 16;
   localparam int unsigned ScaleW = 4;
   localparam int unsigned DistW = 20;

   typedef logic [PhaseW-1:0] phase_type;
   typedef logic [EventW-1:0] event_type;
   typedef logic [ByteW-1:0] byte_type;

   localparam phase_type PH_HUNT = 3'd0;
   localparam phase_type PH_LEN_LO = 3'd1;
   localparam phase_type PH_LEN_HI = 3'd2;
   localparam phase_type PH_PAYLOAD = 3'd3;
   localparam phase_type PH_TAIL = 3'd4;

   localparam event_type EV_NONE = 2'd0;
   localparam event_type EV_ACCEPT = 2'd1;
   localparam event_type EV_BAD_LEN = 2'd2;
   localparam event_type EV_BAD_TAIL = 2'd3;

   localparam logic [CsrIndexW-1:0] CSR_STALE_LIMIT = 1'd0;
   localparam logic [CsrIndexW-1:0] CSR_DIST_SCALE = 1'd1;

   localparam logic [AgeW-1:0] STALE_LIMIT_RESET = 16'd5000;
   localparam logic [ScaleW-1:0] DIST_SCALE_RESET = 4'd10;
   localparam logic [AgeW-1:0] AGE_MAX = 16'hFFFF;
   localparam logic [15:0] MIN_PAYLOAD = 16'd3;

   localparam byte_type HDR_BYTES [4] = '{8'hF4, 8'hF3, 8'hF2, 8'hF1};
   localparam byte_type TAIL_BYTES [4] = '{8'hF8, 8'hF7, 8'hF6, 8'hF5};

endpackage

`default_nettype wire

// File: hw/rtl/radar_report_frame_parser.sv
// ----------------------------------------------------------------------------
// Radar report frame parser
// Parses received bytes into report frames, latches presence and scaled
// distance from accepted frames, and ages them on millisecond ticks.
// ----------------------------------------------------------------------------
// The result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle unless an untaken result beat holds off
// input; parser state and result register update in the same cycle as the handshake.
// Reset: synchronous and active high; the parser returns to header hunt,
// no frame is latched and the CSR registers take their default values.
`default_nettype none

module radar_report_frame_parser #(
   parameter int unsigned MAX_PAYLOAD = 64
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire                             req_op,
   input  wire [rrfp_pkg::ByteW-1:0]       req_rx_byte,
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output logic [rrfp_pkg::EventW-1:0]     rsp_frame_event,
   output logic                            rsp_presence,
   output logic [rrfp_pkg::DistW-1:0]      rsp_dist_mm,
   output logic                            rsp_quality,
   input  wire                             csr_wr_en,
   input  wire [rrfp_pkg::CsrIndexW-1:0]   csr_index,
   input  wire [rrfp_pkg::CsrDataW-1:0]    csr_wdata
);
   import rrfp_pkg::*;

   localparam int unsigned LenW = $clog2(MAX_PAYLOAD + 1);

   logic [AgeW-1:0]   stale_limit_ff;
   logic [ScaleW-1:0] dist_scale_ff;

   phase_type         phase_ff, phase_in;
   logic [1:0]        match_ff, match_in;
   byte_type          len_low_ff, len_low_in;
   logic [LenW-1:0]   pay_len_ff, pay_len_in;
   logic [LenW-1:0]   byte_cnt_ff, byte_cnt_in;
   logic              pend_pres_ff, pend_pres_in;
   logic [RawW-1:0]   pend_raw_ff, pend_raw_in;
   logic              tail_ok_ff, tail_ok_in;
   logic              lat_pres_ff, lat_pres_in;
   logic [DistW-1:0]  lat_dist_ff, lat_dist_in;
   logic [AgeW-1:0]   age_ff, age_in;
   logic              seen_ff, seen_in;

   logic              rsp_valid_ff;
   event_type         rsp_event_ff, event_in;
   logic              rsp_pres_ff, rsp_pres_in;
   logic [DistW-1:0]  rsp_dist_ff, rsp_dist_in;
   logic              rsp_qual_ff, rsp_qual_in;

   logic              accept;
   logic              fresh;
   logic [15:0]       len_word;
   logic [LenW-1:0]   cnt_inc;
   logic              tail_ok_now;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;

   assign len_word = {req_rx_byte, len_low_ff};
   assign cnt_inc = byte_cnt_ff + LenW'(1);
   assign tail_ok_now = tail_ok_ff && (req_rx_byte == TAIL_BYTES[match_ff]);

   always_comb begin
      phase_in = phase_ff;
      match_in = match_ff;
      len_low_in = len_low_ff;
      pay_len_in = pay_len_ff;
      byte_cnt_in = byte_cnt_ff;
      pend_pres_in = pend_pres_ff;
      pend_raw_in = pend_raw_ff;
      tail_ok_in = tail_ok_ff;
      lat_pres_in = lat_pres_ff;
      lat_dist_in = lat_dist_ff;
      age_in = age_ff;
      seen_in = seen_ff;
      event_in = EV_NONE;
      if (accept) begin
         if (req_op) begin
            if (age_ff != AGE_MAX) begin
               age_in = age_ff + AgeW'(1);
            end
         end else begin
            unique case (phase_ff)
               PH_HUNT: begin
                  if (req_rx_byte == HDR_BYTES[match_ff]) begin
                     if (match_ff == 2'd3) begin
                        match_in = 2'd0;
                        phase_in = PH_LEN_LO;
                     end else begin
                        match_in = match_ff + 2'd1;
                     end
                  end else begin
                     match_in = (req_rx_byte == HDR_BYTES[0]) ? 2'd1 : 2'd0;
                  end
               end
               PH_LEN_LO: begin
                  len_low_in = req_rx_byte;
                  phase_in = PH_LEN_HI;
               end
               PH_LEN_HI: begin
                  if (len_word < MIN_PAYLOAD || len_word > 16'(MAX_PAYLOAD)) begin
                     event_in = EV_BAD_LEN;
                     phase_in = PH_HUNT;
                     match_in = 2'd0;
                  end else begin
                     pay_len_in = len_word[LenW-1:0];
                     byte_cnt_in = '0;
                     phase_in = PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  if (byte_cnt_ff == LenW'(0)) begin
                     pend_pres_in = (req_rx_byte != 8'd0);
                  end else if (byte_cnt_ff == LenW'(1)) begin
                     pend_raw_in = {pend_raw_ff[15:8], req_rx_byte};
                  end else if (byte_cnt_ff == LenW'(2)) begin
                     pend_raw_in = {req_rx_byte, pend_raw_ff[7:0]};
                  end
                  byte_cnt_in = cnt_inc;
                  if (cnt_inc >= pay_len_ff) begin
                     phase_in = PH_TAIL;
                     match_in = 2'd0;
                     tail_ok_in = 1'b1;
                  end
               end
               PH_TAIL: begin
                  tail_ok_in = tail_ok_now;
                  if (match_ff == 2'd3) begin
                     if (tail_ok_now) begin
                        event_in = EV_ACCEPT;
                        lat_pres_in = pend_pres_ff;
                        if (pend_pres_ff && pend_raw_ff != '0) begin
                           lat_dist_in = {4'd0, pend_raw_ff} * {16'd0, dist_scale_ff};
                        end else begin
                           lat_dist_in = '0;
                        end
                        age_in = '0;
                        seen_in = 1'b1;
                     end else begin
                        event_in = EV_BAD_TAIL;
                     end
                     phase_in = PH_HUNT;
                     match_in = 2'd0;
                     tail_ok_in = 1'b1;
                  end else begin
                     match_in = match_ff + 2'd1;
                  end
               end
               default: begin
                  phase_in = PH_HUNT;
                  match_in = 2'd0;
               end
            endcase
         end
      end
   end

   assign fresh = seen_in && (age_in < stale_limit_ff);
   assign rsp_pres_in = fresh && lat_pres_in;
   assign rsp_dist_in = fresh ? lat_dist_in : '0;
   assign rsp_qual_in = !(fresh || event_in == EV_ACCEPT);

   always_ff @(posedge clock) begin
      if (reset) begin
         stale_limit_ff <= STALE_LIMIT_RESET;
         dist_scale_ff <= DIST_SCALE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_STALE_LIMIT: stale_limit_ff <= csr_wdata;
            CSR_DIST_SCALE: dist_scale_ff <= csr_wdata[ScaleW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         match_ff <= 2'd0;
         byte_cnt_ff <= '0;
         tail_ok_ff <= 1'b1;
         age_ff <= '0;
         seen_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         match_ff <= match_in;
         byte_cnt_ff <= byte_cnt_in;
         tail_ok_ff <= tail_ok_in;
         age_ff <= age_in;
         seen_ff <= seen_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      len_low_ff <= len_low_in;
      pay_len_ff <= pay_len_in;
      pend_pres_ff <= pend_pres_in;
      pend_raw_ff <= pend_raw_in;
      lat_pres_ff <= lat_pres_in;
      lat_dist_ff <= lat_dist_in;
      if (accept) begin
         rsp_event_ff <= event_in;
         rsp_pres_ff <= rsp_pres_in;
         rsp_dist_ff <= rsp_dist_in;
         rsp_qual_ff <= rsp_qual_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_frame_event = rsp_event_ff;
   assign rsp_presence = rsp_pres_ff;
   assign rsp_dist_mm = rsp_dist_ff;
   assign rsp_quality = rsp_qual_ff;

   // A beat that reports a latched value must not be flagged invalid.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_qual_ff) |-> (!rsp_pres_ff && rsp_dist_ff == '0))
      else $error("invalid-quality beat carries latched data");

   // An accepted frame always reports good quality.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_event_ff == EV_ACCEPT) |-> !rsp_qual_ff)
      else $error("accepted frame reported with invalid quality");

   // The payload counter never reaches the stored length while in payload.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (byte_cnt_ff < pay_len_ff))
      else $error("payload byte count overran the payload length");

endmodule

`default_nettype wire
